FILE: hw/rtl/ssf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_pkg
// Shared constants and control types of the shortest-seek-first scheduler.
// ----------------------------------------------------------------------------
package ssf_pkg;

  localparam int MaxRequests = 64;
  localparam int IdxW        = $clog2(MaxRequests);
  localparam int CntW        = $clog2(MaxRequests + 1);
  localparam int CylW        = 16;
  localparam int DistW       = CylW + 1;
  localparam int SumW        = 23;
  localparam int TotalW      = 22;

  // no request found yet: one above any real distance
  localparam logic [DistW-1:0] DistNone = {1'b1, {CylW{1'b0}}};

  typedef struct packed {
    logic shift;
    logic clr_served;
  } ssf_cell_ctrl_t;

  typedef struct packed {
    logic init;
    logic check;
  } ssf_pick_ctrl_t;

endpackage

FILE: hw/rtl/ssf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_cell
// One slot of the request ring: holds a cylinder and its served mark and
// passes both to its neighbor while the ring rotates.
// ----------------------------------------------------------------------------
module ssf_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ssf_pkg::ssf_cell_ctrl_t ctrl_i,
  input  logic                    load_i,
  input  logic [15:0]             load_cyl_i,
  input  logic                    mark_i,
  input  logic [15:0]             nb_cyl_i,
  input  logic                    nb_served_i,
  output logic [15:0]             cyl_o,
  output logic                    served_o
);
  import ssf_pkg::*;

  logic [CylW-1:0] cyl_q, cyl_d;
  logic            served_q, served_d;

  always_comb begin
    cyl_d    = cyl_q;
    served_d = served_q;
    if (ctrl_i.clr_served) begin
      served_d = 1'b0;
    end else if (ctrl_i.shift) begin
      cyl_d    = nb_cyl_i;
      served_d = nb_served_i;
    end else begin
      if (load_i) begin
        cyl_d = load_cyl_i;
      end
      if (mark_i) begin
        served_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cyl_q <= cyl_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      served_q <= 1'b0;
    end else begin
      served_q <= served_d;
    end
  end

  assign cyl_o    = cyl_q;
  assign served_o = served_q;

endmodule

FILE: hw/rtl/ssf_pick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_pick
// Nearest-request tracker at the ring exit: compares one slot a cycle against
// the current head and keeps the best candidate.
// ----------------------------------------------------------------------------
module ssf_pick (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ssf_pkg::ssf_pick_ctrl_t ctrl_i,
  input  logic [15:0]             head_i,
  input  logic [15:0]             cyl_i,
  input  logic                    served_i,
  input  logic [ssf_pkg::IdxW-1:0] idx_i,
  input  logic [ssf_pkg::CntW-1:0] count_i,
  output logic [15:0]             best_cyl_o,
  output logic [ssf_pkg::DistW-1:0] best_dist_o,
  output logic [ssf_pkg::IdxW-1:0] best_idx_o
);
  import ssf_pkg::*;

  logic [CylW-1:0]  best_cyl_q, best_cyl_d;
  logic [DistW-1:0] best_dist_q, best_dist_d;
  logic [IdxW-1:0]  best_idx_q, best_idx_d;
  logic [CylW-1:0]  seek_dist;
  logic             eligible;

  assign seek_dist = (cyl_i >= head_i) ? (cyl_i - head_i) : (head_i - cyl_i);
  assign eligible  = (CntW'(idx_i) < count_i) && !served_i;

  always_comb begin
    best_cyl_d  = best_cyl_q;
    best_dist_d = best_dist_q;
    best_idx_d  = best_idx_q;
    if (ctrl_i.init) begin
      best_dist_d = DistNone;
      best_idx_d  = '0;
    end else if (ctrl_i.check && eligible && ({1'b0, seek_dist} < best_dist_q)) begin
      // strict compare keeps the lowest index on a tie
      best_cyl_d  = cyl_i;
      best_dist_d = {1'b0, seek_dist};
      best_idx_d  = idx_i;
    end
  end

  always_ff @(posedge clk_i) begin
    best_cyl_q <= best_cyl_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_dist_q <= DistNone;
      best_idx_q  <= '0;
    end else begin
      best_dist_q <= best_dist_d;
      best_idx_q  <= best_idx_d;
    end
  end

  assign best_cyl_o  = best_cyl_q;
  assign best_dist_o = best_dist_q;
  assign best_idx_o  = best_idx_q;

endmodule

FILE: hw/rtl/shortest_seek_first_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_seek_first_scheduler_core
// Collects a batch of request cylinders and emits them in shortest-seek-first
// order with seek distance and running total.
// ----------------------------------------------------------------------------
// channel   | handshake                 | payload
// request   | start, busy               | request_cylinder_i, last_request_i
// result    | result_strobe_o           | served_cylinder_o, seek_distance_o,
//           |                           | total_seek_o, last_served_o, overflow_o
// config    | cfg_valid_i, cfg_ready_o  | cfg_data_i (start head)
//
// a request that is not last is stored and busy stays low
// a last request starts scheduling: each selection rotates the 64-slot ring
// once past one comparator, then commits the nearest unserved request; busy
// stays high until the whole batch is served, and each result is strobed in
// the cycle after its commit
// reset clears the served marks, counters and start head; the receiver
// cannot stall, results come out at their fixed cycle
// ----------------------------------------------------------------------------
module shortest_seek_first_scheduler_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] request_cylinder_i,
  input  logic        last_request_i,
  output logic        result_strobe_o,
  output logic [15:0] served_cylinder_o,
  output logic [15:0] seek_distance_o,
  output logic [21:0] total_seek_o,
  output logic        last_served_o,
  output logic        overflow_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import ssf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CylW-1:0] start_head_q, start_head_d;
  logic [CylW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] serve_q, serve_d;
  logic [IdxW-1:0] scan_q, scan_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic            dropped_q, dropped_d;

  logic              strobe_q, strobe_d;
  logic [CylW-1:0]   out_cyl_q, out_cyl_d;
  logic [CylW-1:0]   out_dist_q, out_dist_d;
  logic [TotalW-1:0] out_total_q, out_total_d;
  logic              out_last_q, out_last_d;
  logic              out_ovf_q, out_ovf_d;

  ssf_cell_ctrl_t  cell_ctrl;
  ssf_pick_ctrl_t  pick_ctrl;
  logic            accept;
  logic            store_en;
  logic            final_sel;
  logic [SumW-1:0] sum_next;

  logic [CylW-1:0] cell_cyl    [MaxRequests];
  logic            cell_served [MaxRequests];

  logic [CylW-1:0]  best_cyl;
  logic [DistW-1:0] best_dist;
  logic [IdxW-1:0]  best_idx;

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign store_en    = accept && (count_q < CntW'(MaxRequests));
  assign final_sel   = ((serve_q + CntW'(1)) == count_q);
  assign sum_next    = sum_q + SumW'(best_dist);

  assign cell_ctrl.shift      = (state_q == ST_SCAN);
  assign cell_ctrl.clr_served = (state_q == ST_EMIT) && final_sel;
  assign pick_ctrl.init       = (state_q == ST_IDLE) || (state_q == ST_EMIT);
  assign pick_ctrl.check      = (state_q == ST_SCAN);

  // ring: slot i takes from slot i+1, slot 0 feeds the comparator
  for (genvar gi = 0; gi < MaxRequests; gi++) begin : g_cell
    localparam int Nb = (gi + 1) % MaxRequests;
    ssf_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .load_i      (store_en && (count_q[IdxW-1:0] == IdxW'(gi))),
      .load_cyl_i  (request_cylinder_i),
      .mark_i      ((state_q == ST_EMIT) && (best_idx == IdxW'(gi))),
      .nb_cyl_i    (cell_cyl[Nb]),
      .nb_served_i (cell_served[Nb]),
      .cyl_o       (cell_cyl[gi]),
      .served_o    (cell_served[gi])
    );
  end

  ssf_pick u_pick (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (pick_ctrl),
    .head_i      (head_q),
    .cyl_i       (cell_cyl[0]),
    .served_i    (cell_served[0]),
    .idx_i       (scan_q),
    .count_i     (count_q),
    .best_cyl_o  (best_cyl),
    .best_dist_o (best_dist),
    .best_idx_o  (best_idx)
  );

  always_comb begin
    state_d      = state_q;
    start_head_d = start_head_q;
    head_d       = head_q;
    count_d      = count_q;
    serve_d      = serve_q;
    scan_d       = scan_q;
    sum_d        = sum_q;
    dropped_d    = dropped_q;
    strobe_d     = 1'b0;
    out_cyl_d    = out_cyl_q;
    out_dist_d   = out_dist_q;
    out_total_d  = out_total_q;
    out_last_d   = out_last_q;
    out_ovf_d    = out_ovf_q;

    if (cfg_valid_i && cfg_ready_o) begin
      start_head_d = cfg_data_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (store_en) begin
            count_d = count_q + CntW'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (last_request_i) begin
            head_d  = start_head_q;
            serve_d = '0;
            scan_d  = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_q == IdxW'(MaxRequests - 1)) begin
          scan_d  = '0;
          state_d = ST_EMIT;
        end else begin
          scan_d = scan_q + IdxW'(1);
        end
      end
      ST_EMIT: begin
        strobe_d    = 1'b1;
        out_cyl_d   = best_cyl;
        out_dist_d  = best_dist[CylW-1:0];
        out_total_d = sum_next[TotalW-1:0];
        out_last_d  = final_sel;
        out_ovf_d   = dropped_q;
        head_d      = best_cyl;
        serve_d     = serve_q + CntW'(1);
        if (final_sel) begin
          count_d   = '0;
          sum_d     = '0;
          dropped_d = 1'b0;
          state_d   = ST_IDLE;
        end else begin
          sum_d   = sum_next;
          state_d = ST_SCAN;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      start_head_q <= '0;
      head_q       <= '0;
      count_q      <= '0;
      serve_q      <= '0;
      scan_q       <= '0;
      sum_q        <= '0;
      dropped_q    <= 1'b0;
      strobe_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      start_head_q <= start_head_d;
      head_q       <= head_d;
      count_q      <= count_d;
      serve_q      <= serve_d;
      scan_q       <= scan_d;
      sum_q        <= sum_d;
      dropped_q    <= dropped_d;
      strobe_q     <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_cyl_q   <= out_cyl_d;
    out_dist_q  <= out_dist_d;
    out_total_q <= out_total_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign result_strobe_o   = strobe_q;
  assign served_cylinder_o = out_cyl_q;
  assign seek_distance_o   = out_dist_q;
  assign total_seek_o      = out_total_q;
  assign last_served_o     = out_last_q;
  assign overflow_o        = out_ovf_q;

  a_strobe_after_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(state_q == ST_EMIT))
    else $error("result strobe without a committed selection");

  a_ring_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (scan_q == '0))
    else $error("selection committed with the ring out of alignment");

  a_found_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (best_dist != DistNone))
    else $error("selection pass found no unserved request");

  a_batch_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> ((count_q != '0) && (serve_q < count_q)))
    else $error("scheduling with no request left to serve");

endmodule
